FILE: rtl/core/nfa_epsilon_removal_defines.svh
// ----------------------------------------------------------------------------
// NFA epsilon removal: assertion macros
// Shared property forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef NFA_EPSILON_REMOVAL_DEFINES_SVH
`define NFA_EPSILON_REMOVAL_DEFINES_SVH

// same-cycle implication
`define NFA_ER_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nfa_er: same-cycle check failed");

// next-cycle implication
`define NFA_ER_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nfa_er: next-cycle check failed");

`endif

FILE: rtl/core/nfa_er_pkg.sv
// ----------------------------------------------------------------------------
// NFA epsilon removal: package
// Field widths, codes, register defaults and shared types.
// ----------------------------------------------------------------------------
package nfa_er_pkg;

   localparam int DEF_STATES  = 32;
   localparam int DEF_SYMBOLS = 10;

   localparam int KIND_W   = 2;
   localparam int STATE_W  = 5;
   localparam int SYMBOL_W = 4;
   localparam int RESULT_W = 32;

   localparam int NUM_STATES_W  = 6;
   localparam int NUM_SYMBOLS_W = 4;
   localparam int FINALS_W      = 32;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TRANS  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FINALS = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STATES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SYMBOLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FINALS      = 2'd2;

   localparam logic [NUM_STATES_W-1:0]  RST_NUM_STATES  = 6'd3;
   localparam logic [NUM_SYMBOLS_W-1:0] RST_NUM_SYMBOLS = 4'd3;
   localparam logic [FINALS_W-1:0]      RST_FINALS      = 32'd4;

   typedef struct packed {
      logic eps_we;
      logic sym_we;
   } edge_wr_type;

endpackage

FILE: rtl/core/nfa_er_channels.sv
// ----------------------------------------------------------------------------
// NFA epsilon removal: channel interfaces
// Valid/ready request and response channels with their payload.
// ----------------------------------------------------------------------------
interface nfa_er_req_if;
   logic                                valid;
   logic                                ready;
   logic [nfa_er_pkg::KIND_W-1:0]       kind;
   logic [nfa_er_pkg::STATE_W-1:0]      from_state;
   logic [nfa_er_pkg::SYMBOL_W-1:0]     symbol;
   logic                                is_epsilon;
   logic [nfa_er_pkg::STATE_W-1:0]      to_state;

   modport source (output valid, kind, from_state, symbol, is_epsilon, to_state,
                   input ready);
   modport sink   (input valid, kind, from_state, symbol, is_epsilon, to_state,
                   output ready);
endinterface

interface nfa_er_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [nfa_er_pkg::RESULT_W-1:0]     result_set;

   modport source (output valid, result_set, input ready);
   modport sink   (input valid, result_set, output ready);
endinterface

FILE: rtl/core/nfa_er_edge_store.sv
// ----------------------------------------------------------------------------
// NFA epsilon removal: edge store
// Epsilon and symbol edge rows in two single-port RAMs with registered reads,
// swept to zero after reset.
// ----------------------------------------------------------------------------
module nfa_er_edge_store #(
   parameter int STATES  = nfa_er_pkg::DEF_STATES,
   parameter int SYMBOLS = nfa_er_pkg::DEF_SYMBOLS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  nfa_er_pkg::edge_wr_type              wr,
   input  logic [$clog2(STATES)-1:0]            row_addr,
   input  logic [$clog2(STATES*SYMBOLS)-1:0]    sym_addr,
   input  logic [STATES-1:0]                    wdata,
   output logic [STATES-1:0]                    eps_q,
   output logic [STATES-1:0]                    sym_q,
   output logic                                 store_ready
);

   localparam int SW    = $clog2(STATES);
   localparam int AW    = $clog2(STATES*SYMBOLS);
   localparam int DEPTH = STATES * SYMBOLS;

   logic [STATES-1:0] eps_ram_ff [STATES];
   logic [STATES-1:0] sym_ram_ff [DEPTH];
   logic [STATES-1:0] eps_q_ff;
   logic [STATES-1:0] sym_q_ff;
   logic [AW-1:0]     clr_ff;
   logic [AW-1:0]     clr_in;
   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic              clr_eps;

   assign clr_eps     = {1'b0, clr_ff} < (AW+1)'(STATES);
   assign clr_in      = clr_ff + AW'(1);
   assign clr_busy_in = clr_busy_ff && (clr_ff != AW'(DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_ff      <= clr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         if (clr_eps) begin
            eps_ram_ff[clr_ff[SW-1:0]] <= '0;
         end
      end else if (wr.eps_we) begin
         eps_ram_ff[row_addr] <= wdata;
      end
      eps_q_ff <= eps_ram_ff[row_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         sym_ram_ff[clr_ff] <= '0;
      end else if (wr.sym_we) begin
         sym_ram_ff[sym_addr] <= wdata;
      end
      sym_q_ff <= sym_ram_ff[sym_addr];
   end

   assign eps_q       = eps_q_ff;
   assign sym_q       = sym_q_ff;
   assign store_ready = !clr_busy_ff;

endmodule

FILE: rtl/core/nfa_epsilon_removal.sv
// ----------------------------------------------------------------------------
// NFA epsilon removal: top level
// Bitset NFA edge tables with epsilon-free transition and final-mask queries,
// worked out row by row through one shared OR/test unit under a sequencer.
// ----------------------------------------------------------------------------
//   channel  dir  handshake     beat
//   req_bus  in   valid/ready   kind, from_state, symbol, is_epsilon, to_state
//   rsp_bus  out  valid/ready   result_set
//   csr_*    in   write enable  csr_index, csr_wdata
//
// Add edge: read row, write row back; no response. One item at a time.
// Transition query: two closures of up to n+1 passes each on the epsilon RAM
// plus one pass on the symbol RAM.
// Finals query: one backward closure; n = states in use.
// After reset both RAMs are swept to zero while req is held off.
// A pending response holds the sequencer in its emit step until taken.
// ----------------------------------------------------------------------------
`include "nfa_epsilon_removal_defines.svh"

module nfa_epsilon_removal #(
   parameter int STATES  = nfa_er_pkg::DEF_STATES,
   parameter int SYMBOLS = nfa_er_pkg::DEF_SYMBOLS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   nfa_er_req_if.sink                           req_bus,
   nfa_er_rsp_if.source                         rsp_bus,
   input  logic                                 csr_we,
   input  logic [nfa_er_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nfa_er_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SW   = $clog2(STATES);
   localparam int SYMW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int AW   = $clog2(STATES*SYMBOLS);
   localparam int NSW  = nfa_er_pkg::NUM_STATES_W;
   localparam int MW   = nfa_er_pkg::NUM_SYMBOLS_W + 1;
   localparam int FW   = nfa_er_pkg::STATE_W + 1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_ADD_RD = 8'b0000_0010,
      ST_ADD_WR = 8'b0000_0100,
      ST_CLOS_A = 8'b0000_1000,
      ST_GATHER = 8'b0001_0000,
      ST_CLOS_B = 8'b0010_0000,
      ST_BACK   = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [NSW-1:0]                        num_states_ff;
   logic [nfa_er_pkg::NUM_SYMBOLS_W-1:0]  num_symbols_ff;
   logic [nfa_er_pkg::FINALS_W-1:0]       final_states_ff;

   logic [SW-1:0]     idx_ff, idx_in;
   logic [SW-1:0]     row_ff, row_in;
   logic              issue_ff, issue_in;
   logic              dv_ff, dv_in;
   logic              last_ff, last_in;
   logic              grew_ff, grew_in;
   logic [STATES-1:0] set_ff, set_in;
   logic [STATES-1:0] acc_ff, acc_in;
   logic [STATES-1:0] res_ff, res_in;
   logic [SYMW-1:0]   sym_ff, sym_in;
   logic [SW-1:0]     add_to_ff, add_to_in;
   logic              add_eps_ff, add_eps_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STATES-1:0] rsp_data_ff;
   logic              rsp_load;

   logic [NSW-1:0]    n_w;
   logic [MW-1:0]     m_w;
   logic [STATES-1:0] mask_n;
   logic [STATES-1:0] row_bit;
   logic              is_last;
   logic              req_fire;
   logic              add_ok;
   logic              qry_ok;
   logic              store_ready;

   nfa_er_pkg::edge_wr_type edge_wr;
   logic [AW-1:0]           sym_addr;
   logic [STATES-1:0]       wdata;
   logic [STATES-1:0]       eps_q;
   logic [STATES-1:0]       sym_q;

   logic              scan_st;
   logic [STATES-1:0] unit_base;
   logic [STATES-1:0] unit_add;
   logic              unit_hit;
   logic [STATES-1:0] unit_out;
   logic              unit_grew;
   logic              pass_end;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff   <= nfa_er_pkg::RST_NUM_STATES;
         num_symbols_ff  <= nfa_er_pkg::RST_NUM_SYMBOLS;
         final_states_ff <= nfa_er_pkg::RST_FINALS;
      end else if (csr_we) begin
         unique case (csr_index)
            nfa_er_pkg::CSR_NUM_STATES:  num_states_ff   <= csr_wdata[NSW-1:0];
            nfa_er_pkg::CSR_NUM_SYMBOLS:
               num_symbols_ff <= csr_wdata[nfa_er_pkg::NUM_SYMBOLS_W-1:0];
            nfa_er_pkg::CSR_FINALS:      final_states_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign n_w = (num_states_ff > NSW'(STATES)) ? NSW'(STATES) : num_states_ff;
   assign m_w = ({1'b0, num_symbols_ff} > MW'(SYMBOLS)) ? MW'(SYMBOLS)
                                                         : {1'b0, num_symbols_ff};

   always_comb begin
      for (int i = 0; i < STATES; i++) begin
         mask_n[i] = NSW'(i) < n_w;
      end
   end

   assign row_bit  = {{(STATES-1){1'b0}}, 1'b1} << row_ff;
   assign is_last  = (NSW'(idx_ff) + NSW'(1)) == n_w;
   assign req_fire = req_bus.valid && req_bus.ready;

   assign add_ok = ({1'b0, req_bus.from_state} < FW'(STATES))
                && ({1'b0, req_bus.to_state} < FW'(STATES))
                && (req_bus.is_epsilon || ({1'b0, req_bus.symbol} < m_w));
   assign qry_ok = ({1'b0, req_bus.from_state} < n_w)
                && ({1'b0, req_bus.symbol} < m_w);

   // shared row unit
   assign scan_st   = (state_ff == ST_CLOS_A) || (state_ff == ST_GATHER)
                   || (state_ff == ST_CLOS_B) || (state_ff == ST_BACK);
   assign unit_base = (state_ff == ST_GATHER) ? acc_ff : set_ff;
   assign unit_add  = (state_ff == ST_BACK) ? row_bit
                    : ((state_ff == ST_GATHER) ? sym_q : eps_q);
   assign unit_hit  = (state_ff == ST_BACK) ? |(eps_q & set_ff) : set_ff[row_ff];
   assign unit_out  = (dv_ff && unit_hit) ? (unit_base | unit_add) : unit_base;
   assign unit_grew = unit_out != unit_base;
   assign pass_end  = dv_ff && last_ff;

   assign sym_addr = AW'(idx_ff) * AW'(SYMBOLS) + AW'(sym_ff);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      row_in     = row_ff;
      issue_in   = issue_ff;
      dv_in      = 1'b0;
      last_in    = last_ff;
      grew_in    = grew_ff;
      set_in     = set_ff;
      acc_in     = acc_ff;
      res_in     = res_ff;
      sym_in     = sym_ff;
      add_to_in  = add_to_ff;
      add_eps_in = add_eps_ff;
      rsp_load   = 1'b0;
      edge_wr    = '0;
      wdata      = (add_eps_ff ? eps_q : sym_q)
                 | ({{(STATES-1){1'b0}}, 1'b1} << add_to_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.kind)
                  nfa_er_pkg::KIND_ADD: begin
                     if (add_ok) begin
                        idx_in     = req_bus.from_state[SW-1:0];
                        add_to_in  = req_bus.to_state[SW-1:0];
                        add_eps_in = req_bus.is_epsilon;
                        sym_in     = req_bus.symbol[SYMW-1:0];
                        state_in   = ST_ADD_RD;
                     end
                  end
                  nfa_er_pkg::KIND_TRANS: begin
                     sym_in = req_bus.symbol[SYMW-1:0];
                     if (qry_ok) begin
                        set_in   = {{(STATES-1){1'b0}}, 1'b1}
                                   << req_bus.from_state[SW-1:0];
                        idx_in   = '0;
                        issue_in = 1'b1;
                        grew_in  = 1'b0;
                        state_in = ST_CLOS_A;
                     end else begin
                        res_in   = '0;
                        state_in = ST_EMIT;
                     end
                  end
                  nfa_er_pkg::KIND_FINALS: begin
                     if (n_w == '0) begin
                        res_in   = '0;
                        state_in = ST_EMIT;
                     end else begin
                        set_in   = final_states_ff[STATES-1:0];
                        idx_in   = '0;
                        issue_in = 1'b1;
                        grew_in  = 1'b0;
                        state_in = ST_BACK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD_RD: begin
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            edge_wr.eps_we = add_eps_ff;
            edge_wr.sym_we = !add_eps_ff;
            state_in       = ST_IDLE;
         end
         ST_CLOS_A, ST_GATHER, ST_CLOS_B, ST_BACK: begin
            if (issue_ff) begin
               dv_in    = 1'b1;
               row_in   = idx_ff;
               last_in  = is_last;
               idx_in   = idx_ff + SW'(1);
               issue_in = !is_last;
            end
            grew_in = grew_ff | unit_grew;
            if (state_ff == ST_GATHER) begin
               acc_in = unit_out;
            end else begin
               set_in = unit_out;
            end
            if (pass_end) begin
               idx_in   = '0;
               issue_in = 1'b1;
               grew_in  = 1'b0;
               if (state_ff == ST_GATHER) begin
                  set_in   = unit_out & mask_n;
                  state_in = ST_CLOS_B;
               end else if (!(grew_ff || unit_grew)) begin
                  issue_in = 1'b0;
                  if (state_ff == ST_CLOS_A) begin
                     acc_in   = '0;
                     issue_in = 1'b1;
                     state_in = ST_GATHER;
                  end else if (state_ff == ST_CLOS_B) begin
                     res_in   = unit_out;
                     state_in = ST_EMIT;
                  end else begin
                     res_in   = unit_out & mask_n;
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      row_ff     <= row_in;
      last_ff    <= last_in;
      grew_ff    <= grew_in;
      set_ff     <= set_in;
      acc_ff     <= acc_in;
      res_ff     <= res_in;
      sym_ff     <= sym_in;
      add_to_ff  <= add_to_in;
      add_eps_ff <= add_eps_in;
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   nfa_er_edge_store #(
      .STATES  (STATES),
      .SYMBOLS (SYMBOLS)
   ) u_edge_store (
      .clock       (clock),
      .reset       (reset),
      .wr          (edge_wr),
      .row_addr    (idx_ff),
      .sym_addr    (sym_addr),
      .wdata       (wdata),
      .eps_q       (eps_q),
      .sym_q       (sym_q),
      .store_ready (store_ready)
   );

   assign req_bus.ready      = (state_ff == ST_IDLE) && store_ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.result_set = nfa_er_pkg::RESULT_W'(rsp_data_ff);

   `NFA_ER_ASSERT_NXT(a_set_grows, clock, reset,
      (state_ff == ST_CLOS_A || state_ff == ST_CLOS_B || state_ff == ST_BACK),
      ((set_ff & $past(set_ff)) == $past(set_ff)))
   `NFA_ER_ASSERT_IMP(a_no_write_in_scan, clock, reset, scan_st,
      !(edge_wr.eps_we || edge_wr.sym_we))
   `NFA_ER_ASSERT_NXT(a_query_busy, clock, reset,
      (req_fire && (req_bus.kind == nfa_er_pkg::KIND_TRANS
                 || req_bus.kind == nfa_er_pkg::KIND_FINALS)),
      !req_bus.ready)
   `NFA_ER_ASSERT_IMP(a_rsp_in_table, clock, reset, rsp_bus.valid,
      ((rsp_bus.result_set >> STATES) == '0))

endmodule

FILE: bench/nfa_er_checker.sv
// ----------------------------------------------------------------------------
// NFA epsilon removal: result checker
// Watches the request, response and register ports, keeps its own copy of
// the edge tables and settings, works out each query's answer when the query
// beat is taken and compares every response beat with the oldest answer due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfa_er_checker
   import nfa_er_pkg::*;
#(
   parameter int STATES  = DEF_STATES,
   parameter int SYMBOLS = DEF_SYMBOLS
) (
   input  logic                  clock,
   input  logic                  reset,
   nfa_er_req_if                 req_bus,
   nfa_er_rsp_if                 rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   logic [RESULT_W-1:0]      eps_rows [STATES];
   logic [RESULT_W-1:0]      sym_rows [STATES][SYMBOLS];
   logic [NUM_STATES_W-1:0]  cfg_states;
   logic [NUM_SYMBOLS_W-1:0] cfg_symbols;
   logic [FINALS_W-1:0]      cfg_finals;
   logic [RESULT_W-1:0]      awaited_sets [$];
   int                       failures = 0;
   int                       outstanding = 0;

   assign fail_count = failures;
   assign pending    = outstanding;

   function automatic int used_states();
      return (int'(cfg_states) > STATES) ? STATES : int'(cfg_states);
   endfunction

   function automatic int used_symbols();
      return (int'(cfg_symbols) > SYMBOLS) ? SYMBOLS : int'(cfg_symbols);
   endfunction

   function automatic logic [RESULT_W-1:0] eps_closure(input logic [RESULT_W-1:0] seed,
                                                       input int n);
      logic [RESULT_W-1:0] set_now;
      logic [RESULT_W-1:0] wider;
      bit                  grew;
      set_now = seed;
      grew    = 1'b1;
      while (grew) begin
         grew = 1'b0;
         for (int s = 0; s < n; s++) begin
            if (set_now[s]) begin
               wider = set_now | eps_rows[s];
               if (wider != set_now) begin
                  set_now = wider;
                  grew    = 1'b1;
               end
            end
         end
      end
      return set_now;
   endfunction

   function automatic logic [RESULT_W-1:0] next_state_set(input logic [STATE_W-1:0]  from_q,
                                                          input logic [SYMBOL_W-1:0] sym);
      int                  n;
      logic [RESULT_W-1:0] start_set;
      logic [RESULT_W-1:0] reach;
      logic [RESULT_W-1:0] successors;
      n          = used_states();
      successors = '0;
      if (int'(from_q) < n && int'(sym) < used_symbols()) begin
         start_set = eps_closure(RESULT_W'(1) << from_q, n);
         reach     = '0;
         for (int p = 0; p < n; p++)
            if (start_set[p]) reach |= sym_rows[p][sym];
         for (int p = 0; p < n; p++)
            if (reach[p]) successors |= eps_closure(RESULT_W'(1) << p, n);
      end
      return successors;
   endfunction

   function automatic logic [RESULT_W-1:0] final_state_mask();
      int                  n;
      logic [RESULT_W-1:0] mask;
      n    = used_states();
      mask = '0;
      for (int s = 0; s < n; s++)
         if ((eps_closure(RESULT_W'(1) << s, n) & cfg_finals) != '0) mask[s] = 1'b1;
      return mask;
   endfunction

   always @(posedge clock) begin
      logic [RESULT_W-1:0] want;
      if (reset) begin
         foreach (eps_rows[s]) eps_rows[s] = '0;
         foreach (sym_rows[s, c]) sym_rows[s][c] = '0;
         cfg_states  = RST_NUM_STATES;
         cfg_symbols = RST_NUM_SYMBOLS;
         cfg_finals  = RST_FINALS;
         awaited_sets.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_STATES:  cfg_states  = csr_wdata[NUM_STATES_W-1:0];
               CSR_NUM_SYMBOLS: cfg_symbols = csr_wdata[NUM_SYMBOLS_W-1:0];
               CSR_FINALS:      cfg_finals  = csr_wdata[FINALS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_sets.size() == 0) begin
               $error("result_set: expected nothing, actual %h", rsp_bus.result_set);
               failures++;
            end else begin
               want = awaited_sets.pop_front();
               if (rsp_bus.result_set !== want) begin
                  $error("result_set: expected %h, actual %h", want, rsp_bus.result_set);
                  failures++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            case (req_bus.kind)
               KIND_ADD: begin
                  if (int'(req_bus.from_state) < STATES && int'(req_bus.to_state) < STATES) begin
                     if (req_bus.is_epsilon)
                        eps_rows[req_bus.from_state][req_bus.to_state] = 1'b1;
                     else if (int'(req_bus.symbol) < used_symbols())
                        sym_rows[req_bus.from_state][req_bus.symbol][req_bus.to_state] = 1'b1;
                  end
               end
               KIND_TRANS:
                  awaited_sets.push_back(next_state_set(req_bus.from_state, req_bus.symbol));
               KIND_FINALS:
                  awaited_sets.push_back(final_state_mask());
               default: ;
            endcase
         end
      end
      outstanding = awaited_sets.size();
   end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// NFA epsilon removal: testbench top
// Drives edge additions, transition and final-mask queries through a run of
// register settings, from empty and single-state tables up to full and
// oversized counts, with random gaps on both channels and one long response
// hold-off; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import nfa_er_pkg::*;

   localparam logic [KIND_W-1:0]    KIND_NONE    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE    = 2'd3;
   localparam int                   DRAIN_CYCLES = 2300;
   localparam int                   LONG_HOLD    = 700;
   localparam int                   PHASES       = 8;
   localparam int                   PHASE_BEATS  = 33;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending;
   bit                    no_idle = 1'b0;
   int                    holds_asked = 0;
   int                    beats_sent = 0;
   int                    queries_sent = 0;
   int                    settings_seen = 0;

   nfa_er_req_if req_bus ();
   nfa_er_rsp_if rsp_bus ();

   nfa_epsilon_removal #(
      .STATES  (DEF_STATES),
      .SYMBOLS (DEF_SYMBOLS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nfa_er_checker #(
      .STATES  (DEF_STATES),
      .SYMBOLS (DEF_SYMBOLS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   task automatic send_item(input logic [KIND_W-1:0]   kind,
                            input logic [STATE_W-1:0]  from_q,
                            input logic [SYMBOL_W-1:0] sym,
                            input logic                eps,
                            input logic [STATE_W-1:0]  dest);
      while (!no_idle && $urandom_range(99) < 11) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.from_state <= from_q;
      req_bus.symbol     <= sym;
      req_bus.is_epsilon <= eps;
      req_bus.to_state   <= dest;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
      if (kind == KIND_TRANS || kind == KIND_FINALS) queries_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] states_word,
                            input logic [CSR_DATA_W-1:0] symbols_word,
                            input logic [CSR_DATA_W-1:0] finals_word);
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_STATES;
      csr_wdata <= states_word;
      @(negedge clock);
      csr_index <= CSR_NUM_SYMBOLS;
      csr_wdata <= symbols_word;
      @(negedge clock);
      csr_index <= CSR_FINALS;
      csr_wdata <= finals_word;
      @(negedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_seen++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] with_noise(input int value, input int width);
      logic [CSR_DATA_W-1:0] low_mask;
      low_mask = (CSR_DATA_W'(1) << width) - CSR_DATA_W'(1);
      return (CSR_DATA_W'($urandom) & ~low_mask) | (CSR_DATA_W'(value) & low_mask);
   endfunction

   task automatic random_item(input int n_use, input int m_use);
      int                  pick;
      logic [STATE_W-1:0]  from_q;
      logic [STATE_W-1:0]  dest;
      logic [SYMBOL_W-1:0] sym;
      pick   = $urandom_range(99);
      from_q = (n_use > 0) ? STATE_W'($urandom_range(n_use - 1)) : STATE_W'($urandom);
      dest   = (n_use > 0) ? STATE_W'($urandom_range(n_use - 1)) : STATE_W'($urandom);
      sym    = (m_use > 0) ? SYMBOL_W'($urandom_range(m_use - 1)) : SYMBOL_W'($urandom);
      if (pick < 7)
         send_item(KIND_W'($urandom_range(3)), STATE_W'($urandom), SYMBOL_W'($urandom),
                   1'($urandom), STATE_W'($urandom));
      else if (pick < 57)
         send_item(KIND_ADD, from_q, sym, $urandom_range(99) < 40, dest);
      else if (pick < 90)
         send_item(KIND_TRANS, from_q, sym, 1'($urandom), STATE_W'($urandom));
      else
         send_item(KIND_FINALS, STATE_W'($urandom), SYMBOL_W'($urandom), 1'($urandom),
                   STATE_W'($urandom));
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      int holds_served;
      hold_left     = 0;
      holds_served  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(99) >= 11);
         end
      end
   end

   initial begin
      #35_000_000;
      $display("nfa_epsilon_removal test failed");
      $finish;
   end

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_ADD;
      req_bus.from_state = '0;
      req_bus.symbol     = '0;
      req_bus.is_epsilon = 1'b0;
      req_bus.to_state   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // settings straight out of reset
      send_item(KIND_FINALS, 5'd0, 4'd0, 1'b0, 5'd0);
      send_item(KIND_ADD, 5'd0, 4'd0, 1'b1, 5'd1);
      send_item(KIND_ADD, 5'd1, 4'd0, 1'b1, 5'd2);
      send_item(KIND_ADD, 5'd2, 4'd2, 1'b0, 5'd0);
      send_item(KIND_ADD, 5'd0, 4'd3, 1'b0, 5'd1);
      send_item(KIND_ADD, 5'd31, 4'd0, 1'b1, 5'd0);
      send_item(KIND_TRANS, 5'd0, 4'd2, 1'b0, 5'd0);
      send_item(KIND_TRANS, 5'd3, 4'd0, 1'b0, 5'd0);
      send_item(KIND_TRANS, 5'd0, 4'd5, 1'b0, 5'd0);
      send_item(KIND_NONE, 5'd31, 4'd15, 1'b1, 5'd31);
      send_item(KIND_ADD, 5'd2, 4'd15, 1'b1, 5'd31);
      send_item(KIND_ADD, 5'd31, 4'd15, 1'b0, 5'd31);
      send_item(KIND_FINALS, 5'd0, 4'd0, 1'b0, 5'd0);

      settle();
      configure(32'd32, 32'd10, 32'h8000_0001);
      send_item(KIND_TRANS, 5'd31, 4'd9, 1'b0, 5'd0);
      send_item(KIND_ADD, 5'd31, 4'd9, 1'b0, 5'd0);
      send_item(KIND_TRANS, 5'd31, 4'd9, 1'b0, 5'd0);
      send_item(KIND_FINALS, 5'd31, 4'd15, 1'b1, 5'd31);

      settle();
      configure(32'd0, 32'd0, 32'd0);
      send_item(KIND_ADD, 5'd3, 4'd0, 1'b0, 5'd4);
      send_item(KIND_TRANS, 5'd0, 4'd0, 1'b0, 5'd0);
      send_item(KIND_FINALS, 5'd0, 4'd0, 1'b0, 5'd0);

      settle();
      configure(32'd63, 32'd15, 32'hFFFF_FFFF);
      send_item(KIND_FINALS, 5'd0, 4'd0, 1'b0, 5'd0);
      send_item(KIND_TRANS, 5'd2, 4'd2, 1'b0, 5'd0);
      send_item(KIND_TRANS, 5'd2, 4'd10, 1'b0, 5'd0);
      send_item(KIND_TRANS, 5'd2, 4'd15, 1'b0, 5'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         int                    n;
         int                    m;
         logic [CSR_DATA_W-1:0] finals_word;
         case (phase)
            2: begin
               n = 32;
               m = 10;
            end
            4: begin
               n = $urandom_range(63, 33);
               m = $urandom_range(15, 11);
            end
            5: begin
               n = 1;
               m = 1;
            end
            6: begin
               n = $urandom_range(16);
               m = $urandom_range(15);
            end
            default: begin
               n = $urandom_range(12, 2);
               m = $urandom_range(10, 1);
            end
         endcase
         finals_word = ($urandom_range(3) == 0) ? '1 : CSR_DATA_W'($urandom);
         settle();
         configure(with_noise(n, NUM_STATES_W), with_noise(m, NUM_SYMBOLS_W), finals_word);
         if (phase == 1) holds_asked <= holds_asked + 1;
         no_idle <= (phase == 3);
         for (int k = 0; k < PHASE_BEATS; k++)
            random_item((n > DEF_STATES) ? DEF_STATES : n, (m > DEF_SYMBOLS) ? DEF_SYMBOLS : m);
      end

      settle();
      $display("covered %0d request beats (%0d queries) over %0d register settings,",
               beats_sent, queries_sent, settings_seen);
      $display("from empty and single-state tables to full and oversized counts");
      if (fail_count == 0 && pending == 0)
         $display("nfa_epsilon_removal test passed");
      else
         $display("nfa_epsilon_removal test failed");
      $finish;
   end

endmodule

FILE: nfa_epsilon_removal.f
+incdir+rtl/core
rtl/core/nfa_er_pkg.sv
rtl/core/nfa_er_channels.sv
rtl/core/nfa_er_edge_store.sv
rtl/core/nfa_epsilon_removal.sv
bench/nfa_er_checker.sv
bench/testbench.sv
